// ----- hw/rtl/avt_pkg.sv -----
// Shared types, constants and floating-point helpers of the affine vec3 transform.
package avt_pkg;

    localparam int LANES       = 3;
    localparam int EXP_W       = 12;
    localparam int SIG_W       = 64;
    localparam int ADD_STAGES  = 4;
    localparam int LANE_STAGES = 2 + 3 * ADD_STAGES;
    localparam int CFG_WORDS   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_LANE0_XY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANE0_ZT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LANE1_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LANE1_ZT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LANE2_XY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LANE2_ZT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd6;

    localparam logic [SIG_W-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [SIG_W-1:0] QUIET_BIT = 64'h4000_0000_0000_0000;

    typedef enum logic [1:0] {CL_ZERO, CL_FIN, CL_INF, CL_NAN} cls_t;

    // Finite value is sig * 2^(e-63) with sig normalized (bit 63 set).
    typedef struct packed {
        cls_t                    cls;
        logic                    neg;
        logic signed [EXP_W-1:0] e;
        logic [SIG_W-1:0]        sig;
    } xval_t;

    typedef struct packed {
        logic [31:0] vec_x;
        logic [31:0] vec_y;
        logic [31:0] vec_z;
    } vec_in_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
    } vec_out_t;

    // Operand pairs of one lane in fold order; a operands are loaded quieted.
    typedef struct packed {
        logic [LANES-1:0][31:0] a;
        logic [LANES-1:0][31:0] b;
        logic [31:0]            trans;
        logic                   round53;
    } lane_ops_t;

    function automatic xval_t mk_indef();
        xval_t r;
        r.cls = CL_NAN;
        r.neg = 1'b1;
        r.e   = '0;
        r.sig = TOP_BIT | QUIET_BIT;
        return r;
    endfunction

    // NaN propagation: quiet beats signaling, then larger significand, then a.
    function automatic xval_t nan_pick(input xval_t a, input xval_t b);
        xval_t r;
        logic  qa;
        logic  qb;
        qa = a.sig[62];
        qb = b.sig[62];
        if (a.cls == CL_NAN && b.cls == CL_NAN)
        begin
            if (qa != qb)
                r = qa ? a : b;
            else
                r = (b.sig > a.sig) ? b : a;
        end
        else
        begin
            r = (a.cls == CL_NAN) ? a : b;
        end
        r.sig = r.sig | QUIET_BIT;
        return r;
    endfunction

endpackage

// ----- hw/rtl/avt_fmul.sv -----
// Single-stage exact product of two unpacked binary32 values.
module avt_fmul
    import avt_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  xval_t a,
    input  xval_t b,
    output xval_t prod
);

    xval_t       prod_reg;
    xval_t       prod_next;
    logic [47:0] p;

    always_comb
    begin
        p = a.sig[63:40] * b.sig[63:40];
        prod_next.cls = CL_FIN;
        prod_next.neg = a.neg ^ b.neg;
        prod_next.e   = '0;
        prod_next.sig = '0;
        if (a.cls == CL_NAN || b.cls == CL_NAN)
        begin
            prod_next = nan_pick(a, b);
        end
        else if (a.cls == CL_INF || b.cls == CL_INF)
        begin
            if (a.cls == CL_ZERO || b.cls == CL_ZERO)
                prod_next = mk_indef();
            else
                prod_next.cls = CL_INF;
        end
        else if (a.cls == CL_ZERO || b.cls == CL_ZERO)
        begin
            prod_next.cls = CL_ZERO;
        end
        else
        begin
            prod_next.e   = a.e + b.e + $signed({{(EXP_W-1){1'b0}}, p[47]});
            prod_next.sig = p[47] ? {p, 16'b0} : {p[46:0], 17'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/avt_fadd.sv -----
// Four-stage adder rounding to 53 or 64 significand bits, nearest-even.
module avt_fadd
    import avt_pkg::*;
(
    input  logic                  clk,
    input  logic [ADD_STAGES-1:0] en,
    input  xval_t                 a,
    input  xval_t                 b,
    input  logic                  round53,
    output xval_t                 sum
);

    // Stage 1: special operands, magnitude order and exponent distance.
    xval_t                   s1_spec_val_next;
    logic                    s1_spec_next;
    xval_t                   big;
    xval_t                   sml;
    logic signed [EXP_W:0]   dd;
    logic                    s1_spec_reg;
    xval_t                   s1_spec_val_reg;
    logic [SIG_W-1:0]        s1_big_sig_reg;
    logic [SIG_W-1:0]        s1_sml_sig_reg;
    logic signed [EXP_W-1:0] s1_e_reg;
    logic                    s1_neg_reg;
    logic                    s1_sub_reg;
    logic [7:0]              s1_d_reg;

    always_comb
    begin
        s1_spec_next     = 1'b1;
        s1_spec_val_next = a;
        if (a.cls == CL_NAN || b.cls == CL_NAN)
        begin
            s1_spec_val_next = nan_pick(a, b);
        end
        else if (a.cls == CL_INF || b.cls == CL_INF)
        begin
            if (a.cls == CL_INF && b.cls == CL_INF && a.neg != b.neg)
                s1_spec_val_next = mk_indef();
            else
                s1_spec_val_next = (a.cls == CL_INF) ? a : b;
        end
        else if (a.cls == CL_ZERO && b.cls == CL_ZERO)
        begin
            s1_spec_val_next.neg = a.neg & b.neg;
        end
        else if (a.cls == CL_ZERO)
        begin
            s1_spec_val_next = b;
        end
        else if (b.cls == CL_ZERO)
        begin
            s1_spec_val_next = a;
        end
        else
        begin
            s1_spec_next = 1'b0;
        end
        if (a.e < b.e || (a.e == b.e && a.sig < b.sig))
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        dd = (EXP_W+1)'(big.e) - (EXP_W+1)'(sml.e);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_spec_reg     <= s1_spec_next;
            s1_spec_val_reg <= s1_spec_val_next;
            s1_big_sig_reg  <= big.sig;
            s1_sml_sig_reg  <= sml.sig;
            s1_e_reg        <= big.e;
            s1_neg_reg      <= big.neg;
            s1_sub_reg      <= big.neg ^ sml.neg;
            s1_d_reg        <= (dd > (EXP_W+1)'(128)) ? 8'd128 : dd[7:0];
        end
    end

    // Stage 2: align the smaller operand with a sticky bit, then add or subtract.
    logic [127:0]            x_al;
    logic [127:0]            y_al;
    logic [127:0]            y_sh;
    logic                    y_st;
    logic [127:0]            s2_z_next;
    logic [127:0]            s2_z_reg;
    logic signed [EXP_W-1:0] s2_e_reg;
    logic                    s2_neg_reg;
    logic                    s2_spec_reg;
    xval_t                   s2_spec_val_reg;

    always_comb
    begin
        x_al = {1'b0, s1_big_sig_reg, 63'b0};
        y_al = {1'b0, s1_sml_sig_reg, 63'b0};
        y_sh = y_al >> s1_d_reg;
        y_st = |(y_al & ~({128{1'b1}} << s1_d_reg));
        y_sh[0] = y_sh[0] | y_st;
        s2_z_next = s1_sub_reg ? (x_al - y_sh) : (x_al + y_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_z_reg        <= s2_z_next;
            s2_e_reg        <= s1_e_reg;
            s2_neg_reg      <= s1_neg_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
        end
    end

    // Stage 3: leading-zero count of the raw sum.
    logic [6:0]              lz;
    logic [127:0]            s3_z_reg;
    logic [6:0]              s3_k_reg;
    logic                    s3_zero_reg;
    logic signed [EXP_W-1:0] s3_e_reg;
    logic                    s3_neg_reg;
    logic                    s3_spec_reg;
    xval_t                   s3_spec_val_reg;

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (s2_z_reg[i])
                lz = 7'(127 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_z_reg        <= s2_z_reg;
            s3_k_reg        <= lz;
            s3_zero_reg     <= (s2_z_reg == '0);
            s3_e_reg        <= s2_e_reg;
            s3_neg_reg      <= s2_neg_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
        end
    end

    // Stage 4: normalize and round to the working precision.
    logic [127:0]     zn;
    logic [SIG_W-1:0] zh;
    logic [SIG_W-1:0] zl;
    logic [SIG_W-1:0] zh_m;
    logic [SIG_W:0]   unit;
    logic [SIG_W:0]   zr;
    logic             rb;
    logic             sticky;
    logic             lsb;
    xval_t            sum_next;
    xval_t            sum_reg;

    always_comb
    begin
        zn = s3_z_reg << s3_k_reg;
        zh = zn[127:64];
        zl = zn[63:0];
        if (round53)
        begin
            rb     = zh[10];
            sticky = (|zh[9:0]) | (|zl);
            lsb    = zh[11];
            zh_m   = {zh[63:11], 11'b0};
            unit   = 65'h800;
        end
        else
        begin
            rb     = zl[63];
            sticky = |zl[62:0];
            lsb    = zh[0];
            zh_m   = zh;
            unit   = 65'h1;
        end
        zr = {1'b0, zh_m} + ((rb & (sticky | lsb)) ? unit : '0);
        sum_next.cls = CL_FIN;
        sum_next.neg = s3_neg_reg;
        sum_next.e   = s3_e_reg + EXP_W'(1) - $signed({{(EXP_W-7){1'b0}}, s3_k_reg});
        sum_next.sig = zr[63:0];
        if (zr[64])
        begin
            sum_next.sig = TOP_BIT;
            sum_next.e   = sum_next.e + EXP_W'(1);
        end
        if (s3_spec_reg)
        begin
            sum_next = s3_spec_val_reg;
        end
        else if (s3_zero_reg)
        begin
            sum_next.cls = CL_ZERO;
            sum_next.neg = 1'b0;
            sum_next.e   = '0;
            sum_next.sig = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ----- hw/rtl/avt_lane.sv -----
// One output lane: unpack, three products, three chained sums and binary32 packing.
module avt_lane
    import avt_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  lane_ops_t              ops,
    output logic [31:0]            result
);

    function automatic xval_t load32(input logic [31:0] bits, input logic quiet);
        xval_t      r;
        logic [7:0] ex;
        logic [22:0] fr;
        logic [4:0] msb;
        ex    = bits[30:23];
        fr    = bits[22:0];
        r.neg = bits[31];
        r.e   = '0;
        r.sig = '0;
        r.cls = CL_FIN;
        msb   = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (fr[i])
                msb = 5'(i);
        end
        if (ex == 8'hFF)
        begin
            if (fr == '0)
            begin
                r.cls = CL_INF;
            end
            else
            begin
                r.cls = CL_NAN;
                r.sig = TOP_BIT | {1'b0, fr, 40'b0};
                r.sig[62] = r.sig[62] | quiet;
            end
        end
        else if (ex == 8'h00)
        begin
            if (fr == '0)
            begin
                r.cls = CL_ZERO;
            end
            else
            begin
                r.sig = SIG_W'(fr) << (6'd63 - {1'b0, msb});
                r.e   = $signed({{(EXP_W-5){1'b0}}, msb}) - EXP_W'(149);
            end
        end
        else
        begin
            r.sig = {1'b1, fr, 40'b0};
            r.e   = $signed({{(EXP_W-8){1'b0}}, ex}) - EXP_W'(127);
        end
        return r;
    endfunction

    function automatic logic [31:0] store32(input xval_t v);
        logic [31:0]        s;
        logic [31:0]        bits;
        logic signed [12:0] shs;
        logic [6:0]         sh;
        logic [SIG_W-1:0]   rbv;
        logic [23:0]        m;
        logic               rb;
        logic               st;
        logic [24:0]        mr;
        logic [EXP_W-1:0]   be;
        s   = {v.neg, 31'b0};
        shs = (v.e < -EXP_W'(126)) ? (-13'sd86 - 13'(v.e)) : 13'sd40;
        sh  = shs[6:0];
        m   = 24'(v.sig >> sh);
        rbv = v.sig >> (sh - 7'd1);
        rb  = rbv[0];
        st  = |(v.sig & ~({SIG_W{1'b1}} << (sh - 7'd1)));
        mr  = {1'b0, m} + {24'b0, rb & (st | m[0])};
        be  = v.e + EXP_W'(126);
        bits = {1'b0, be[7:0], 23'b0} + {7'b0, mr};
        if (v.cls == CL_NAN)
            store32 = {v.neg, 8'hFF, v.sig[62:40]};
        else if (v.cls == CL_INF)
            store32 = s | 32'h7F80_0000;
        else if (v.cls == CL_ZERO)
            store32 = s;
        else if (v.e > EXP_W'(127))
            store32 = s | 32'h7F80_0000;
        else if (shs >= 13'sd65)
            store32 = s;
        else if (v.e < -EXP_W'(126))
            store32 = s | {7'b0, mr};
        else if (bits >= 32'h7F80_0000)
            store32 = s | 32'h7F80_0000;
        else
            store32 = s | bits;
    endfunction

    xval_t opa_reg [LANES];
    xval_t opb_reg [LANES];
    xval_t t0_reg;
    xval_t prod [LANES];
    xval_t p2_d_reg [ADD_STAGES];
    xval_t t_d_reg [2 * ADD_STAGES + 1];
    xval_t sum1;
    xval_t sum2;
    xval_t sum3;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                opa_reg[i] <= load32(ops.a[i], 1'b1);
                opb_reg[i] <= load32(ops.b[i], 1'b0);
            end
            t0_reg <= load32(ops.trans, 1'b0);
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_mul
        avt_fmul u_mul (
            .clk  (clk),
            .en   (en[1]),
            .a    (opa_reg[i]),
            .b    (opb_reg[i]),
            .prod (prod[i])
        );
    end

    // The third product and the translation wait for the sums ahead of them.
    always_ff @(posedge clk)
    begin
        if (en[1])
            t_d_reg[0] <= t0_reg;
        for (int i = 1; i < 2 * ADD_STAGES + 1; i++)
        begin
            if (en[1 + i])
                t_d_reg[i] <= t_d_reg[i - 1];
        end
        if (en[2])
            p2_d_reg[0] <= prod[2];
        for (int i = 1; i < ADD_STAGES; i++)
        begin
            if (en[2 + i])
                p2_d_reg[i] <= p2_d_reg[i - 1];
        end
    end

    avt_fadd u_add1 (
        .clk     (clk),
        .en      (en[2 + ADD_STAGES - 1:2]),
        .a       (prod[0]),
        .b       (prod[1]),
        .round53 (ops.round53),
        .sum     (sum1)
    );

    avt_fadd u_add2 (
        .clk     (clk),
        .en      (en[2 + 2 * ADD_STAGES - 1:2 + ADD_STAGES]),
        .a       (sum1),
        .b       (p2_d_reg[ADD_STAGES - 1]),
        .round53 (ops.round53),
        .sum     (sum2)
    );

    avt_fadd u_add3 (
        .clk     (clk),
        .en      (en[2 + 3 * ADD_STAGES - 1:2 + 2 * ADD_STAGES]),
        .a       (sum2),
        .b       (t_d_reg[2 * ADD_STAGES]),
        .round53 (ops.round53),
        .sum     (sum3)
    );

    assign result = store32(sum3);

endmodule

// ----- hw/rtl/affine_vec3_transform_f32.sv -----
// Top level of the binary32 affine vec3 transform: configuration, lanes and output stage.
//
// Each transfer on the input channel carries one binary32 vector (x, y, z); the
// block answers with one transformed vector per input, in order. Three identical
// lanes compute out_x, out_y and out_z side by side from the coefficients and
// translations held in configuration; the mode register picks the 53-bit recipe
// with its mixed fold order or the 64-bit recipe folded x, y, z. A new vector
// can be taken every clock cycle unless the output stalls with every stage full.
// Fifteen register stages lie between the ports: per lane one unpack stage, one
// multiply stage and three four-stage adders (operand order, align and add,
// leading-zero count, normalize and round), then the registered output stage
// that merges the three lanes. The input transfer loads the first stage.
// The pipeline stalls stage by stage, so bubbles are squeezed out while the
// output waits and the input keeps accepting until every stage is full.
// Configuration must be written while no vector is in flight.
module affine_vec3_transform_f32
    import avt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vec_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vec_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STAGES_TOTAL = LANE_STAGES + 1;

    // Configuration: two 64-bit words per lane and the precision select.
    logic [CFG_DATA_W-1:0] cfg_word_reg  [CFG_WORDS];
    logic [CFG_DATA_W-1:0] cfg_word_next [CFG_WORDS];
    logic                  mode_reg;
    logic                  mode_next;

    always_comb
    begin
        for (int w = 0; w < CFG_WORDS; w++)
            cfg_word_next[w] = cfg_word_reg[w];
        mode_next = mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LANE0_XY: cfg_word_next[0] = cfg_data;
                REG_LANE0_ZT: cfg_word_next[1] = cfg_data;
                REG_LANE1_XY: cfg_word_next[2] = cfg_data;
                REG_LANE1_ZT: cfg_word_next[3] = cfg_data;
                REG_LANE2_XY: cfg_word_next[4] = cfg_data;
                REG_LANE2_ZT: cfg_word_next[5] = cfg_data;
                REG_MODE:     mode_next        = cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < CFG_WORDS; w++)
                cfg_word_reg[w] <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            for (int w = 0; w < CFG_WORDS; w++)
                cfg_word_reg[w] <= cfg_word_next[w];
            mode_reg <= mode_next;
        end
    end

    // Pipeline occupancy. A stage may load when out_ready is high or when it or
    // any stage after it is empty, so each ready term is a reduction over the
    // valid bits downstream rather than a ripple.
    logic [STAGES_TOTAL-1:0] v_reg;
    logic [STAGES_TOTAL-1:0] v_next;
    logic [STAGES_TOTAL-1:0] stage_rdy;

    for (genvar i = 0; i < STAGES_TOTAL; i++)
    begin : g_rdy
        assign stage_rdy[i] = out_ready | ~(&v_reg[STAGES_TOTAL-1:i]);
    end

    always_comb
    begin
        v_next[0] = stage_rdy[0] ? in_valid : v_reg[0];
        for (int i = 1; i < STAGES_TOTAL; i++)
            v_next[i] = stage_rdy[i] ? v_reg[i - 1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready = stage_rdy[0];

    // Operand routing. In 64-bit mode every lane folds x, y, z. In 53-bit mode
    // lane 0 folds z then y then x, and the other lanes fold x then z then y.
    // The first operand of each product is the one loaded quieted.
    lane_ops_t   lane_ops [LANES];
    logic [31:0] lane_res [LANES];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [CFG_DATA_W-1:0] xy_word;
        logic [CFG_DATA_W-1:0] zt_word;

        assign xy_word = cfg_word_reg[2 * l];
        assign zt_word = cfg_word_reg[2 * l + 1];

        always_comb
        begin
            lane_ops[l].trans   = zt_word[63:32];
            lane_ops[l].round53 = ~mode_reg;
            if (mode_reg)
            begin
                lane_ops[l].a[0] = in_data.vec_x;
                lane_ops[l].b[0] = xy_word[31:0];
                lane_ops[l].a[1] = in_data.vec_y;
                lane_ops[l].b[1] = xy_word[63:32];
                lane_ops[l].a[2] = in_data.vec_z;
                lane_ops[l].b[2] = zt_word[31:0];
            end
            else if (l == 0)
            begin
                lane_ops[l].a[0] = zt_word[31:0];
                lane_ops[l].b[0] = in_data.vec_z;
                lane_ops[l].a[1] = xy_word[63:32];
                lane_ops[l].b[1] = in_data.vec_y;
                lane_ops[l].a[2] = in_data.vec_x;
                lane_ops[l].b[2] = xy_word[31:0];
            end
            else
            begin
                lane_ops[l].a[0] = xy_word[31:0];
                lane_ops[l].b[0] = in_data.vec_x;
                lane_ops[l].a[1] = zt_word[31:0];
                lane_ops[l].b[1] = in_data.vec_z;
                lane_ops[l].a[2] = xy_word[63:32];
                lane_ops[l].b[2] = in_data.vec_y;
            end
        end

        avt_lane u_lane (
            .clk    (clk),
            .en     (stage_rdy[LANE_STAGES-1:0]),
            .ops    (lane_ops[l]),
            .result (lane_res[l])
        );
    end

    // Merging stage: the three lane results are registered as one output vector.
    vec_out_t out_reg;
    vec_out_t out_next;

    always_comb
    begin
        out_next.out_x = lane_res[0];
        out_next.out_y = lane_res[1];
        out_next.out_z = lane_res[2];
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[STAGES_TOTAL-1])
            out_reg <= out_next;
    end

    assign out_data  = out_reg;
    assign out_valid = v_reg[STAGES_TOTAL-1];

    // An empty output stage always leaves room at the input.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output stage is empty");

    // Items in flight change only by input and output transfers.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) == $past($countones(v_reg))
            + $past(in_valid && in_ready) - $past(out_valid && out_ready)))
        else $error("pipeline occupancy does not match transfers");

    // An accepted vector always lands in the first stage.
    a_first_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted vector missing from the first stage");

    // A write to the precision select takes effect on the next cycle.
    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_MODE |=> mode_reg == $past(cfg_data[0]))
        else $error("precision select not updated by its write");

endmodule

// ----- bench/tb_affine_vec3_transform_f32.sv -----
// Self-checking testbench of the binary32 affine vec3 transform with a bit-exact predictor.
`timescale 1ns / 1ps

module tb_affine_vec3_transform_f32;
    import avt_pkg::*;

    // The watchdog ends the run after this many cycles with no transfer on either channel.
    // The longest quiet stretch, the settle time after a drain, a full matrix load,
    // one long input gap, the pipeline depth and one long output stall, is
    // covered by this limit with a wide margin.
    localparam int QUIET_LIMIT = 4000;
    // Pipeline depth from the header of the top level, with some slack.
    localparam int SETTLE_CYCLES = 30;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [63:0] SIG_MSB   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SIG_QUIET = 64'h4000_0000_0000_0000;

    // Handy binary32 patterns for the directed tests.
    localparam logic [31:0] F_PZERO = 32'h0000_0000;
    localparam logic [31:0] F_NZERO = 32'h8000_0000;
    localparam logic [31:0] F_ONE   = 32'h3F80_0000;
    localparam logic [31:0] F_NONE  = 32'hBF80_0000;
    localparam logic [31:0] F_TWO   = 32'h4000_0000;
    localparam logic [31:0] F_PINF  = 32'h7F80_0000;
    localparam logic [31:0] F_NINF  = 32'hFF80_0000;
    localparam logic [31:0] F_MAXF  = 32'h7F7F_FFFF;
    localparam logic [31:0] F_MINSUB = 32'h0000_0001;
    localparam logic [31:0] F_MAXSUB = 32'h007F_FFFF;
    localparam logic [31:0] F_QNAN  = 32'h7FC1_2345;
    localparam logic [31:0] F_SNAN  = 32'hFF80_0ABC;

    typedef enum logic [1:0] {FK_ZERO, FK_FIN, FK_INF, FK_NAN} fkind_t;

    // Extended working value: a finite value is sig * 2^(e-63), sig normalized.
    typedef struct {
        fkind_t      k;
        logic        neg;
        int          e;
        logic [63:0] sig;
    } xf_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    vec_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    vec_out_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration: [lane][x, y, z, translation].
    logic [31:0] coef_sh [3][4];
    logic        wide_mode = 1'b0;

    vec_out_t    pending_vecs[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          idling_on = 1'b0;
    int          ready_hold = 0;

    affine_vec3_transform_f32 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor. Products of two binary32 values are exact; every sum is
    // rounded to 53 or 64 significand bits, nearest-even; each lane is
    // rounded once to binary32 at the end.
    // ------------------------------------------------------------------

    // Widens a binary32 pattern. The first operand of each product gets its
    // NaN quieted; the other operands keep a signaling NaN as it is.
    function automatic xf_t unpack_f32(logic [31:0] b, bit quiet);
        xf_t         r;
        logic [7:0]  ex;
        logic [22:0] fr;
        int          msb;
        ex = b[30:23];
        fr = b[22:0];
        r.neg = b[31];
        r.e = 0;
        r.sig = '0;
        if (ex == 8'hFF)
        begin
            if (fr == 0)
            begin
                r.k = FK_INF;
                return r;
            end
            r.k = FK_NAN;
            r.sig = SIG_MSB | ({41'b0, fr} << 40) | (quiet ? SIG_QUIET : 64'b0);
            return r;
        end
        if (ex == 8'h00)
        begin
            if (fr == 0)
            begin
                r.k = FK_ZERO;
                return r;
            end
            msb = 22;
            while (fr[msb] == 1'b0)
                msb--;
            r.k = FK_FIN;
            r.sig = {41'b0, fr} << (63 - msb);
            r.e = msb - 149;
            return r;
        end
        r.k = FK_FIN;
        r.sig = {1'b1, fr, 40'b0};
        r.e = int'(ex) - 127;
        return r;
    endfunction

    function automatic xf_t default_nan();
        xf_t r;
        r.k = FK_NAN;
        r.neg = 1'b1;
        r.e = 0;
        r.sig = SIG_MSB | SIG_QUIET;
        return r;
    endfunction

    // A quiet NaN beats a signaling one; otherwise the larger significand
    // wins and a tie keeps the first operand. The winner comes out quiet.
    function automatic xf_t choose_nan(xf_t a, xf_t b);
        xf_t r;
        bit  qa;
        bit  qb;
        qa = a.sig[62];
        qb = b.sig[62];
        if (a.k == FK_NAN && b.k == FK_NAN)
        begin
            if (qa != qb)
                r = qa ? a : b;
            else
                r = (b.sig > a.sig) ? b : a;
        end
        else
        begin
            r = (a.k == FK_NAN) ? a : b;
        end
        r.sig = r.sig | SIG_QUIET;
        return r;
    endfunction

    function automatic xf_t mul_exact(xf_t a, xf_t b);
        xf_t         r;
        logic [47:0] p;
        if (a.k == FK_NAN || b.k == FK_NAN)
            return choose_nan(a, b);
        r.neg = a.neg ^ b.neg;
        r.e = 0;
        r.sig = '0;
        if (a.k == FK_INF || b.k == FK_INF)
        begin
            if (a.k == FK_ZERO || b.k == FK_ZERO)
                return default_nan();
            r.k = FK_INF;
            return r;
        end
        if (a.k == FK_ZERO || b.k == FK_ZERO)
        begin
            r.k = FK_ZERO;
            return r;
        end
        r.k = FK_FIN;
        p = a.sig[63:40] * b.sig[63:40];
        r.e = a.e + b.e;
        if (p[47])
        begin
            r.e += 1;
            r.sig = {p, 16'b0};
        end
        else
        begin
            r.sig = {p[46:0], 17'b0};
        end
        return r;
    endfunction

    // Sum rounded to 53 significand bits when round53 is set, else to 64.
    function automatic xf_t add_rounded(xf_t a, xf_t b, bit round53);
        xf_t          r;
        xf_t          big;
        xf_t          sml;
        logic [127:0] xw;
        logic [127:0] yw;
        logic [127:0] zw;
        logic [63:0]  zh;
        logic [63:0]  zl;
        logic [63:0]  unit;
        bit           rb;
        bit           sticky;
        bit           lsb;
        bit           lost;
        int           d;
        int           k;
        if (a.k == FK_NAN || b.k == FK_NAN)
            return choose_nan(a, b);
        if (a.k == FK_INF || b.k == FK_INF)
        begin
            if (a.k == FK_INF && b.k == FK_INF && a.neg != b.neg)
                return default_nan();
            return (a.k == FK_INF) ? a : b;
        end
        if (a.k == FK_ZERO && b.k == FK_ZERO)
        begin
            r = a;
            r.neg = a.neg & b.neg;
            return r;
        end
        if (a.k == FK_ZERO)
            return b;
        if (b.k == FK_ZERO)
            return a;
        if (a.e < b.e || (a.e == b.e && a.sig < b.sig))
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        // Both significands sit one bit below the top of a 128-bit word, so
        // the sum cannot carry out. Alignment shifts fold into a sticky bit.
        d = big.e - sml.e;
        xw = {1'b0, big.sig, 63'b0};
        yw = {1'b0, sml.sig, 63'b0};
        if (d >= 128)
        begin
            yw = 128'd1;
        end
        else if (d > 0)
        begin
            lost = |(yw & ((128'd1 << d) - 128'd1));
            yw = (yw >> d) | {127'b0, lost};
        end
        zw = (big.neg == sml.neg) ? xw + yw : xw - yw;
        if (zw == 0)
        begin
            r.k = FK_ZERO;
            r.neg = 1'b0;
            r.e = 0;
            r.sig = '0;
            return r;
        end
        k = 0;
        while (zw[127] == 1'b0)
        begin
            zw = zw << 1;
            k++;
        end
        r.k = FK_FIN;
        r.neg = big.neg;
        r.e = big.e + 1 - k;
        zh = zw[127:64];
        zl = zw[63:0];
        if (!round53)
        begin
            rb = zl[63];
            sticky = (zl[62:0] != 0);
            lsb = zh[0];
            unit = 64'd1;
        end
        else
        begin
            rb = zh[10];
            sticky = (zh[9:0] != 0) || (zl != 0);
            lsb = zh[11];
            unit = 64'h800;
            zh[10:0] = '0;
        end
        if (rb && (sticky || lsb))
        begin
            zh = zh + unit;
            if (zh == 0)
            begin
                zh = SIG_MSB;
                r.e += 1;
            end
        end
        r.sig = zh;
        return r;
    endfunction

    // Single rounding of an extended value to binary32, with gradual underflow.
    function automatic logic [31:0] pack_f32(xf_t v);
        logic [31:0] s;
        logic [31:0] m;
        logic [31:0] bits;
        int          sh;
        bit          rb;
        bit          st;
        s = {v.neg, 31'b0};
        if (v.k == FK_NAN)
            return s | 32'h7F80_0000 | {9'b0, v.sig[62:40]};
        if (v.k == FK_INF)
            return s | 32'h7F80_0000;
        if (v.k == FK_ZERO)
            return s;
        if (v.e > 127)
            return s | 32'h7F80_0000;
        sh = (v.e < -126) ? 40 + (-126 - v.e) : 40;
        if (sh >= 65)
            return s;
        if (sh == 64)
        begin
            m = '0;
            rb = 1'b1;
            st = (v.sig[62:0] != 0);
        end
        else
        begin
            m = 32'(v.sig >> sh);
            rb = v.sig[sh-1];
            st = ((v.sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0);
        end
        if (rb && (st || m[0]))
            m = m + 1;
        if (v.e < -126)
            return s | m;
        // The hidden bit in m lifts the exponent field by one, so a
        // rounding carry moves into the exponent on its own.
        bits = (32'(v.e + 126) << 23) + m;
        if (bits >= 32'h7F80_0000)
            bits = 32'h7F80_0000;
        return s | bits;
    endfunction

    // One output lane in the fold order of the selected precision mode.
    function automatic logic [31:0] lane_value(int ln, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z);
        xf_t acc;
        if (wide_mode)
        begin
            acc = add_rounded(mul_exact(unpack_f32(x, 1), unpack_f32(coef_sh[ln][0], 0)),
                              mul_exact(unpack_f32(y, 1), unpack_f32(coef_sh[ln][1], 0)), 0);
            acc = add_rounded(acc,
                              mul_exact(unpack_f32(z, 1), unpack_f32(coef_sh[ln][2], 0)), 0);
            acc = add_rounded(acc, unpack_f32(coef_sh[ln][3], 0), 0);
        end
        else if (ln == 0)
        begin
            acc = add_rounded(mul_exact(unpack_f32(coef_sh[0][2], 1), unpack_f32(z, 0)),
                              mul_exact(unpack_f32(coef_sh[0][1], 1), unpack_f32(y, 0)), 1);
            acc = add_rounded(acc,
                              mul_exact(unpack_f32(x, 1), unpack_f32(coef_sh[0][0], 0)), 1);
            acc = add_rounded(acc, unpack_f32(coef_sh[0][3], 0), 1);
        end
        else
        begin
            acc = add_rounded(mul_exact(unpack_f32(coef_sh[ln][0], 1), unpack_f32(x, 0)),
                              mul_exact(unpack_f32(coef_sh[ln][2], 1), unpack_f32(z, 0)), 1);
            acc = add_rounded(acc,
                              mul_exact(unpack_f32(coef_sh[ln][1], 1), unpack_f32(y, 0)), 1);
            acc = add_rounded(acc, unpack_f32(coef_sh[ln][3], 0), 1);
        end
        return pack_f32(acc);
    endfunction

    function automatic vec_out_t transform_vec(vec_in_t v);
        vec_out_t r;
        r.out_x = lane_value(0, v.vec_x, v.vec_y, v.vec_z);
        r.out_y = lane_value(1, v.vec_x, v.vec_y, v.vec_z);
        r.out_z = lane_value(2, v.vec_x, v.vec_y, v.vec_z);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random values.
    // ------------------------------------------------------------------

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Binary32 patterns weighted toward values of similar size, so that
    // sums cancel and round, with every special class mixed in.
    function automatic logic [31:0] rand_f32();
        logic [31:0] b;
        int          pick;
        b = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            b[30:0] = '0;
        else if (pick < 7)
            b[30:0] = {8'hFF, 23'b0};
        else if (pick < 11)
            b[30:23] = 8'hFF;
        else if (pick < 16)
            b[30:23] = 8'h00;
        else if (pick < 21)
            b[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                            : 8'($urandom_range(240, 254));
        else if (pick < 30)
            b[22:0] = {$urandom_range(0, 1) ? 23'h7FFFFF : 23'h0} ^ 23'($urandom_range(0, 7));
        else if (pick < 85)
            b[30:23] = 8'($urandom_range(118, 136));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // The output side stalls with the same gap profile while idling is on.
    always @(negedge clk)
    begin
        if (!idling_on)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            int g;
            g = gap_len();
            ready_hold <= (g > 0) ? g - 1 : 0;
            out_ready <= (g == 0);
        end
    end

    // One vector transfer. Valid stays high from one item to the next unless
    // a gap is taken, so it is never dropped and raised in the same step.
    task automatic send_vec(vec_in_t v);
        int g;
        g = idling_on ? gap_len() : 0;
        @(negedge clk);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic vec_in_t mk_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec_in_t v;
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        return v;
    endfunction

    // Drops valid and waits until every expected vector has come back. The
    // extra cycles let the last result clear the output stage.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_vecs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; the shadow copy follows the same decode as the block.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        int ln;
        int col;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < CFG_WORDS)
        begin
            ln = idx >> 1;
            col = idx[0] * 2;
            coef_sh[ln][col] = value[31:0];
            coef_sh[ln][col+1] = value[63:32];
        end
        else if (idx == REG_MODE)
        begin
            wide_mode = value[0];
        end
    endtask

    task automatic load_matrix(logic [31:0] cx[3], logic [31:0] cy[3], logic [31:0] cz[3],
                               logic [31:0] ct[3], logic [63:0] mode_word);
        write_reg(REG_LANE0_XY, {cy[0], cx[0]});
        write_reg(REG_LANE0_ZT, {ct[0], cz[0]});
        write_reg(REG_LANE1_XY, {cy[1], cx[1]});
        write_reg(REG_LANE1_ZT, {ct[1], cz[1]});
        write_reg(REG_LANE2_XY, {cy[2], cx[2]});
        write_reg(REG_LANE2_ZT, {ct[2], cz[2]});
        write_reg(REG_MODE, mode_word);
    endtask

    // ------------------------------------------------------------------
    // Checking. Expectations are formed at the input transfer, with the
    // configuration that holds while the vector is in flight.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_vecs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h %h %h", out_data.out_x,
                                 out_data.out_y, out_data.out_z);
                end
                else
                begin
                    vec_out_t want;
                    want = pending_vecs.pop_front();
                    if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y
                        || out_data.out_z !== want.out_z)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: out x/y/z expected %h %h %h, got %h %h %h",
                                     want.out_x, want.out_y, want.out_z, out_data.out_x,
                                     out_data.out_y, out_data.out_z);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_vecs.push_back(transform_vec(in_data));
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
                $display("tb_affine_vec3_transform_f32: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // After reset every coefficient is +0 and the 53-bit mode is active, so
    // finite inputs give signed zeros and infinities give the default NaN.
    task automatic test_reset_state();
        send_vec(mk_vec(F_ONE, F_NONE, F_MAXF));
        send_vec(mk_vec(F_NZERO, F_NZERO, F_NZERO));
        send_vec(mk_vec(F_PINF, F_ONE, F_ONE));
        drain_block();
    endtask

    // Field extremes and the special cases: exact cancellation, signed zero
    // sums, inf*0 and inf-inf, NaN selection, overflow and underflow.
    task automatic test_special_cases(bit wide);
        logic [31:0] cx[3];
        logic [31:0] cy[3];
        logic [31:0] cz[3];
        logic [31:0] ct[3];
        cx = '{F_ONE, F_ONE, F_TWO};
        cy = '{F_NONE, F_ONE, F_MAXF};
        cz = '{F_ONE, F_NZERO, F_MINSUB};
        ct = '{F_PZERO, F_NZERO, F_MAXSUB};
        load_matrix(cx, cy, cz, ct, {63'b0, wide});
        send_vec(mk_vec(F_ONE, F_ONE, F_NONE));
        send_vec(mk_vec(F_NZERO, F_PZERO, F_NZERO));
        send_vec(mk_vec(F_NZERO, F_NZERO, F_PZERO));
        send_vec(mk_vec(F_PINF, F_PINF, F_ONE));
        send_vec(mk_vec(F_PINF, F_ONE, F_NINF));
        send_vec(mk_vec(F_QNAN, F_SNAN, F_ONE));
        send_vec(mk_vec(F_SNAN, F_ONE, F_QNAN));
        send_vec(mk_vec(32'h7F80_0001, 32'hFFBF_FFFF, F_ONE));
        send_vec(mk_vec(F_MAXF, F_MAXF, F_MAXF));
        send_vec(mk_vec(F_MINSUB, F_MINSUB, F_MAXSUB));
        send_vec(mk_vec(32'h4B80_0001, 32'hCB80_0000, 32'h3F00_0000));
        send_vec(mk_vec(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
        drain_block();
    endtask

    // NaN coefficients: a signaling coefficient against a signaling input
    // is where the quieting of the first product operand decides the winner.
    task automatic test_nan_coefficients();
        logic [31:0] cx[3];
        logic [31:0] cy[3];
        logic [31:0] cz[3];
        logic [31:0] ct[3];
        cx = '{32'h7F80_0005, 32'hFFC0_0001, F_ONE};
        cy = '{F_ONE, 32'h7F80_0005, F_NINF};
        cz = '{32'hFF80_0003, F_ONE, F_PZERO};
        ct = '{F_PINF, 32'h7FFF_FFFF, F_NINF};
        load_matrix(cx, cy, cz, ct, 64'd0);
        send_vec(mk_vec(32'h7F80_0005, 32'hFF80_0005, 32'h7F80_0003));
        send_vec(mk_vec(F_ONE, F_TWO, F_PINF));
        send_vec(mk_vec(32'hFFC0_0001, F_ONE, F_ONE));
        drain_block();
        write_reg(REG_MODE, 64'd1);
        send_vec(mk_vec(32'h7F80_0005, 32'hFF80_0005, 32'h7F80_0003));
        send_vec(mk_vec(F_ONE, F_TWO, F_PINF));
        drain_block();
    endtask

    // Extreme register contents: all ones everywhere (NaN coefficients and a
    // mode word with bits above bit 0), then an unknown index, then all zeros.
    task automatic test_register_extremes();
        logic [31:0] allone[3];
        logic [31:0] allzero[3];
        allone = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        allzero = '{32'h0, 32'h0, 32'h0};
        load_matrix(allone, allone, allone, allone, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vec(mk_vec(F_ONE, F_TWO, F_NONE));
        send_vec(mk_vec(F_SNAN, F_QNAN, F_PINF));
        drain_block();
        load_matrix(allzero, allzero, allzero, allzero, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vec(mk_vec(F_MAXF, F_NZERO, F_NINF));
        drain_block();
    endtask

    // Random matrices and random vectors, random modes, with idling on
    // in most phases and a phase of back-to-back transfers now and then.
    task automatic test_random_stream(int phases, int per_phase);
        logic [31:0] cx[3];
        logic [31:0] cy[3];
        logic [31:0] cz[3];
        logic [31:0] ct[3];
        for (int p = 0; p < phases; p++)
        begin
            for (int ln = 0; ln < 3; ln++)
            begin
                cx[ln] = rand_f32();
                cy[ln] = rand_f32();
                cz[ln] = rand_f32();
                ct[ln] = rand_f32();
            end
            load_matrix(cx, cy, cz, ct, {$urandom, $urandom});
            idling_on = (p % 4 != 3);
            for (int i = 0; i < per_phase; i++)
                send_vec(mk_vec(rand_f32(), rand_f32(), rand_f32()));
            drain_block();
        end
    endtask

    initial
    begin
        for (int ln = 0; ln < 3; ln++)
            for (int c = 0; c < 4; c++)
                coef_sh[ln][c] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        idling_on = 1'b1;
        test_special_cases(1'b0);
        test_special_cases(1'b1);
        test_nan_coefficients();
        test_register_extremes();
        test_random_stream(10, 155);

        drain_block();
        if (mismatches == 0)
            $display("tb_affine_vec3_transform_f32: PASS");
        else
            $display("tb_affine_vec3_transform_f32: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/avt_pkg.sv
hw/rtl/avt_fmul.sv
hw/rtl/avt_fadd.sv
hw/rtl/avt_lane.sv
hw/rtl/affine_vec3_transform_f32.sv
bench/tb_affine_vec3_transform_f32.sv
